>>> hdl/period_jitter_measure_unit_assert.svh
// ----------------------------------------------------------------------------
// period jitter measure assertion macros
// shared assertion forms, clocked on clk_i and quiet during reset
// ----------------------------------------------------------------------------
`ifndef PERIOD_JITTER_MEASURE_UNIT_ASSERT_SVH
`define PERIOD_JITTER_MEASURE_UNIT_ASSERT_SVH

// condition that holds at every edge out of reset
`define PJM_ASSERT_HOLDS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// same-cycle implication
`define PJM_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> hdl/pjm_pkg.sv
// ----------------------------------------------------------------------------
// pjm_pkg
// shared constants, codes and types of the period jitter measure unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pjm_pkg;

  // default widths
  localparam int unsigned PERIOD_BITS_DEF = 16;
  localparam int unsigned COUNT_BITS_DEF  = 20;

  // fixed field widths
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned ACC_CNT_W  = 20;
  localparam int unsigned SUM_W      = 40;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned BOUND_W    = 16;
  localparam int unsigned RATIO_W    = 12;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // window geometry
  localparam int unsigned WIN_DEPTH = 5;
  localparam int unsigned FILL_W    = 3;
  localparam int unsigned IDX_W     = 3;

  // fixed point scaling
  localparam int unsigned QUOT_W      = 32;
  localparam int unsigned FRAC_SHIFT  = 24;
  localparam int unsigned ABS_SHIFT   = 8;
  localparam int unsigned RATIO_SHIFT = 8;

  // measure modes
  localparam logic [MODE_W-1:0] MODE_LOCAL     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LOCAL_ABS = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RAP       = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PPQ5      = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DDP       = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CEILING = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO   = 2'd3;

  // register reset values
  localparam logic [MODE_W-1:0]  MODE_RST    = MODE_LOCAL;
  localparam logic [BOUND_W-1:0] FLOOR_RST   = 16'd5;
  localparam logic [BOUND_W-1:0] CEILING_RST = 16'd960;
  localparam logic [RATIO_W-1:0] RATIO_RST   = 12'd333;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ACCUM,
    ST_FINAL,
    ST_MUL_NUM,
    ST_MUL_DEN,
    ST_DIV,
    ST_EMIT
  } pjm_state_e;

endpackage

>>> hdl/pjm_mul.sv
// ----------------------------------------------------------------------------
// pjm_mul
// shift-add multiplier, one multiplier bit per cycle, stops early
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pjm_mul import pjm_pkg::*; #(
  parameter int unsigned A_W = SUM_W,
  parameter int unsigned B_W = COUNT_BITS_DEF + 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [A_W-1:0]     a_i,
  input  logic [B_W-1:0]     b_i,
  output logic               done_o,
  output logic [A_W+B_W-1:0] p_o
);

  localparam int unsigned P_W = A_W + B_W;

  logic           busy_q, busy_d;
  logic [P_W-1:0] acc_q, acc_d;
  logic [P_W-1:0] mc_q, mc_d;
  logic [B_W-1:0] mp_q, mp_d;

  // finished once no multiplier bits remain
  assign done_o = busy_q && (mp_q == '0);
  assign p_o    = acc_q;

  // one add and shift per cycle
  always_comb begin
    busy_d = busy_q;
    acc_d  = acc_q;
    mc_d   = mc_q;
    mp_d   = mp_q;
    if (start_i) begin
      busy_d = 1'b1;
      acc_d  = '0;
      mc_d   = P_W'(a_i);
      mp_d   = b_i;
    end else if (busy_q) begin
      if (mp_q == '0) begin
        busy_d = 1'b0;
      end else begin
        if (mp_q[0]) begin
          acc_d = acc_q + mc_q;
        end
        mc_d = mc_q << 1;
        mp_d = mp_q >> 1;
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mc_q  <= mc_d;
    mp_q  <= mp_d;
  end

endmodule

>>> hdl/pjm_div.sv
// ----------------------------------------------------------------------------
// pjm_div
// restoring divider with saturating 32-bit quotient, one bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pjm_div import pjm_pkg::*; #(
  parameter int unsigned N_W = COUNT_BITS_DEF + 3 + SUM_W + QUOT_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [N_W-1:0]        n_i,
  input  logic [N_W-QUOT_W-1:0] d_i,
  output logic                  done_o,
  output logic [QUOT_W-1:0]     q_o
);

  localparam int unsigned CNT_W = $clog2(QUOT_W);

  logic              busy_q, busy_d;
  logic              first_q, first_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [N_W-1:0]    rem_q, rem_d;
  logic [N_W-1:0]    dsh_q, dsh_d;
  logic [QUOT_W-1:0] quo_q, quo_d;
  logic              ge;

  assign done_o = done_q;
  assign q_o    = quo_q;
  assign ge     = rem_q >= dsh_q;

  // overflow test first, then one quotient bit per cycle
  always_comb begin
    busy_d  = busy_q;
    first_d = first_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    dsh_d   = dsh_q;
    quo_d   = quo_q;
    if (start_i) begin
      busy_d  = 1'b1;
      first_d = 1'b1;
      cnt_d   = CNT_W'(QUOT_W - 1);
      rem_d   = n_i;
      dsh_d   = {d_i, {QUOT_W{1'b0}}};
      quo_d   = '0;
    end else if (busy_q) begin
      if (first_q) begin
        if (ge) begin
          quo_d  = '1;
          busy_d = 1'b0;
          done_d = 1'b1;
        end else begin
          dsh_d   = dsh_q >> 1;
          first_d = 1'b0;
        end
      end else begin
        if (ge) begin
          rem_d = rem_q - dsh_q;
        end
        quo_d = {quo_q[QUOT_W-2:0], ge};
        dsh_d = dsh_q >> 1;
        if (cnt_q == '0) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    cnt_q   <= cnt_d;
    rem_q   <= rem_d;
    dsh_q   <= dsh_d;
    quo_q   <= quo_d;
  end

endmodule

>>> hdl/period_jitter_measure_unit.sv
// ----------------------------------------------------------------------------
// period_jitter_measure_unit
// jitter of a pulse train: local, local absolute, rap, ppq5 and ddp
// ----------------------------------------------------------------------------
// Each pulse word enters in the idle state, then the sequencer checks the
// newest pair or window one slot per cycle through a single ratio multiplier
// and, if accepted, adds the participating periods one per cycle. The
// final pulse of a sequence then runs the shared shift-add multiplier twice
// (relative modes only) and the restoring divider before the result word is
// loaded into the output register. Input is stalled while a pulse is in
// work; a waiting result does not block the next pulse, only a further
// final pulse waits for it to be taken. No clearing pass follows reset.
`timescale 1ns / 1ps

module period_jitter_measure_unit import pjm_pkg::*; #(
  parameter int unsigned PERIOD_BITS = PERIOD_BITS_DEF,
  parameter int unsigned COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // pulse input
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [TIME_W-1:0]     pulse_time_i,
  input  logic                  last_pulse_i,
  // result output
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [VALUE_W-1:0]    jitter_value_o,
  output logic                  defined_o,
  output logic [ACC_CNT_W-1:0]  accepted_count_o,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned DEV_W  = PERIOD_BITS + 3;
  localparam int unsigned KDC_W  = COUNT_BITS + 3;
  localparam int unsigned PROD_W = SUM_W + KDC_W;
  localparam int unsigned DIV_W  = PROD_W + QUOT_W;
  localparam int unsigned RP_W   = PERIOD_BITS + RATIO_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [SUM_W-1:0]      SUM_MAX = '1;

  // configuration registers
  logic [MODE_W-1:0]  mode_q;
  logic [BOUND_W-1:0] floor_q;
  logic [BOUND_W-1:0] ceil_q;
  logic [RATIO_W-1:0] ratio_q;

  // sequence state
  pjm_state_e             state_q, state_d;
  logic [TIME_W-1:0]      prev_q, prev_d;
  logic                   have_prev_q, have_prev_d;
  logic                   last_q, last_d;
  logic [PERIOD_BITS-1:0] win_q [WIN_DEPTH];
  logic [PERIOD_BITS-1:0] win_d [WIN_DEPTH];
  logic [PERIOD_BITS-1:0] scan_q [WIN_DEPTH];
  logic [PERIOD_BITS-1:0] scan_d [WIN_DEPTH];
  logic [WIN_DEPTH-1:0]   sat_q, sat_d;
  logic [WIN_DEPTH-1:0]   scan_sat_q, scan_sat_d;
  logic [WIN_DEPTH-1:0]   marks_q, marks_d;
  logic [FILL_W-1:0]      fill_q, fill_d;
  logic [IDX_W-1:0]       n_q, n_d;
  logic [IDX_W-1:0]       k_q, k_d;
  logic [SUM_W-1:0]       dsum_q, dsum_d;
  logic [COUNT_BITS-1:0]  dcnt_q, dcnt_d;
  logic [SUM_W-1:0]       psum_q, psum_d;
  logic [COUNT_BITS-1:0]  pcnt_q, pcnt_d;
  logic [PROD_W-1:0]      nb_q, nb_d;

  // result register
  logic                 out_valid_q, out_valid_d;
  logic [VALUE_W-1:0]   res_val_q, res_val_d;
  logic                 res_def_q, res_def_d;
  logic [VALUE_W-1:0]   out_val_q, out_val_d;
  logic                 out_def_q, out_def_d;
  logic [ACC_CNT_W-1:0] out_cnt_q, out_cnt_d;

  // shared units
  logic              mul_start, mul_done;
  logic [SUM_W-1:0]  mul_a;
  logic [KDC_W-1:0]  mul_b;
  logic [PROD_W-1:0] mul_p;
  logic              div_start, div_done;
  logic [DIV_W-1:0]  div_n;
  logic [PROD_W-1:0] div_d;
  logic [QUOT_W-1:0] div_q;

  // combinational helpers
  logic [TIME_W-1:0]      diff;
  logic [PERIOD_BITS-1:0] lo, hi;
  logic [RP_W-1:0]        hi_sh, lim;
  logic                   ratio_fits, range_ok, last_step, pair_step;
  logic [DEV_W-1:0]       s_sum, c_sum, dev;
  logic [SUM_W:0]         dsum_add, psum_add;
  logic [KDC_W-1:0]       kdc;
  logic                   rel_def;

  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign jitter_value_o   = out_val_q;
  assign defined_o        = out_def_q;
  assign accepted_count_o = out_cnt_q;

  pjm_mul #(
    .A_W (SUM_W),
    .B_W (KDC_W)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  pjm_div #(
    .N_W (DIV_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .n_i     (div_n),
    .d_i     (div_d),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  // pair test on the front of the scan line
  always_comb begin
    lo         = (scan_q[0] < scan_q[1]) ? scan_q[0] : scan_q[1];
    hi         = (scan_q[0] < scan_q[1]) ? scan_q[1] : scan_q[0];
    hi_sh      = RP_W'(hi) << RATIO_SHIFT;
    lim        = RP_W'(ratio_q) * RP_W'(lo);
    ratio_fits = (lo != '0) && (hi_sh <= lim);
    range_ok   = !scan_sat_q[0]
                 && (TIME_W'(scan_q[0]) >= TIME_W'(floor_q))
                 && (TIME_W'(scan_q[0]) <= TIME_W'(ceil_q));
    last_step  = (k_q == (n_q - 1'b1));
    pair_step  = ((k_q + 1'b1) < n_q);
  end

  // difference of the newest pair, or window deviation scaled by the window length
  always_comb begin
    s_sum = '0;
    c_sum = '0;
    case (n_q)
      3'd3: begin
        s_sum = DEV_W'(win_q[0]) + DEV_W'(win_q[1]) + DEV_W'(win_q[2]);
        c_sum = (DEV_W'(win_q[1]) << 1) + DEV_W'(win_q[1]);
      end
      3'd5: begin
        s_sum = DEV_W'(win_q[0]) + DEV_W'(win_q[1]) + DEV_W'(win_q[2])
                + DEV_W'(win_q[3]) + DEV_W'(win_q[4]);
        c_sum = (DEV_W'(win_q[2]) << 2) + DEV_W'(win_q[2]);
      end
      default: begin
        s_sum = DEV_W'(win_q[0]);
        c_sum = DEV_W'(win_q[1]);
      end
    endcase
    dev      = (c_sum > s_sum) ? (c_sum - s_sum) : (s_sum - c_sum);
    dsum_add = {1'b0, dsum_q} + (SUM_W + 1)'(dev);
    psum_add = {1'b0, psum_q} + (SUM_W + 1)'(scan_q[0]);
  end

  // scale of the denominator and result validity
  always_comb begin
    case (mode_q)
      MODE_RAP:  kdc = (KDC_W'(dcnt_q) << 1) + KDC_W'(dcnt_q);
      MODE_PPQ5: kdc = (KDC_W'(dcnt_q) << 2) + KDC_W'(dcnt_q);
      default:   kdc = KDC_W'(dcnt_q);
    endcase
    rel_def = (dcnt_q != '0) && (pcnt_q != '0) && (psum_q != '0);
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    prev_d      = prev_q;
    have_prev_d = have_prev_q;
    last_d      = last_q;
    win_d       = win_q;
    scan_d      = scan_q;
    sat_d       = sat_q;
    scan_sat_d  = scan_sat_q;
    marks_d     = marks_q;
    fill_d      = fill_q;
    n_d         = n_q;
    k_d         = k_q;
    dsum_d      = dsum_q;
    dcnt_d      = dcnt_q;
    psum_d      = psum_q;
    pcnt_d      = pcnt_q;
    nb_d        = nb_q;
    res_val_d   = res_val_q;
    res_def_d   = res_def_q;
    out_valid_d = out_valid_q;
    out_val_d   = out_val_q;
    out_def_d   = out_def_q;
    out_cnt_d   = out_cnt_q;
    mul_start   = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    div_start   = 1'b0;
    div_n       = '0;
    div_d       = '0;
    diff        = pulse_time_i - prev_q;

    // result word taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          last_d      = last_pulse_i;
          prev_d      = pulse_time_i;
          have_prev_d = 1'b1;
          if (have_prev_q) begin
            // new period into the window, long ones saturated and flagged
            for (int i = WIN_DEPTH - 1; i > 0; i--) begin
              win_d[i] = win_q[i-1];
            end
            sat_d   = {sat_q[WIN_DEPTH-2:0], 1'b0};
            marks_d = {marks_q[WIN_DEPTH-2:0], 1'b0};
            if (diff[TIME_W-1:PERIOD_BITS] != '0) begin
              win_d[0] = '1;
              sat_d[0] = 1'b1;
            end else begin
              win_d[0] = diff[PERIOD_BITS-1:0];
            end
            if (fill_q < FILL_W'(WIN_DEPTH)) begin
              fill_d = fill_q + 1'b1;
            end
            scan_d     = win_d;
            scan_sat_d = sat_d;
            case (mode_q)
              MODE_LOCAL, MODE_LOCAL_ABS: n_d = 3'd2;
              MODE_RAP, MODE_DDP:         n_d = 3'd3;
              MODE_PPQ5:                  n_d = 3'd5;
              default:                    n_d = 3'd0;
            endcase
            k_d     = '0;
            state_d = ST_CHECK;
          end else begin
            state_d = ST_FINAL;
          end
        end
      end

      // one slot per cycle: range, then ratio to its older neighbour
      ST_CHECK: begin
        if ((n_q == '0) || (fill_q < n_q)) begin
          state_d = ST_FINAL;
        end else if (!range_ok || (pair_step && !ratio_fits)) begin
          state_d = ST_FINAL;
        end else if (last_step) begin
          if (dcnt_q != CNT_MAX) begin
            dsum_d = dsum_add[SUM_W] ? SUM_MAX : dsum_add[SUM_W-1:0];
            dcnt_d = dcnt_q + 1'b1;
          end
          scan_d  = win_q;
          k_d     = '0;
          state_d = ST_ACCUM;
        end else begin
          for (int i = 0; i < WIN_DEPTH - 1; i++) begin
            scan_d[i] = scan_q[i+1];
          end
          scan_sat_d = scan_sat_q >> 1;
          k_d        = k_q + 1'b1;
        end
      end

      // each period of the window counted once
      ST_ACCUM: begin
        if (!marks_q[k_q]) begin
          marks_d[k_q] = 1'b1;
          if (pcnt_q != CNT_MAX) begin
            psum_d = psum_add[SUM_W] ? SUM_MAX : psum_add[SUM_W-1:0];
            pcnt_d = pcnt_q + 1'b1;
          end
        end
        for (int i = 0; i < WIN_DEPTH - 1; i++) begin
          scan_d[i] = scan_q[i+1];
        end
        if (last_step) begin
          state_d = ST_FINAL;
        end else begin
          k_d = k_q + 1'b1;
        end
      end

      // end of sequence: pick the result path
      ST_FINAL: begin
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if (mode_q == MODE_LOCAL_ABS && dcnt_q != '0) begin
          div_start = 1'b1;
          div_n     = DIV_W'(dsum_q) << ABS_SHIFT;
          div_d     = PROD_W'(dcnt_q);
          res_def_d = 1'b1;
          state_d   = ST_DIV;
        end else if (mode_q != MODE_LOCAL_ABS && mode_q <= MODE_DDP && rel_def) begin
          mul_start = 1'b1;
          mul_a     = dsum_q;
          mul_b     = KDC_W'(pcnt_q);
          res_def_d = 1'b1;
          state_d   = ST_MUL_NUM;
        end else begin
          res_val_d = '0;
          res_def_d = 1'b0;
          state_d   = ST_EMIT;
        end
      end

      ST_MUL_NUM: begin
        if (mul_done) begin
          nb_d      = mul_p;
          mul_start = 1'b1;
          mul_a     = psum_q;
          mul_b     = kdc;
          state_d   = ST_MUL_DEN;
        end
      end

      ST_MUL_DEN: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_n     = DIV_W'(nb_q) << FRAC_SHIFT;
          div_d     = mul_p;
          state_d   = ST_DIV;
        end
      end

      ST_DIV: begin
        if (div_done) begin
          res_val_d = div_q;
          state_d   = ST_EMIT;
        end
      end

      // load the result word and clear the sequence
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_val_d   = res_val_q;
          out_def_d   = res_def_q;
          out_cnt_d   = ACC_CNT_W'(dcnt_q);
          have_prev_d = 1'b0;
          fill_d      = '0;
          marks_d     = '0;
          sat_d       = '0;
          dsum_d      = '0;
          dcnt_d      = '0;
          psum_d      = '0;
          pcnt_d      = '0;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_RST;
      floor_q <= FLOOR_RST;
      ceil_q  <= CEILING_RST;
      ratio_q <= RATIO_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MODE:    mode_q  <= cfg_wdata_i[MODE_W-1:0];
        CFG_FLOOR:   floor_q <= cfg_wdata_i[BOUND_W-1:0];
        CFG_CEILING: ceil_q  <= cfg_wdata_i[BOUND_W-1:0];
        CFG_RATIO:   ratio_q <= cfg_wdata_i[RATIO_W-1:0];
        default:     mode_q  <= mode_q;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      have_prev_q <= 1'b0;
      sat_q       <= '0;
      marks_q     <= '0;
      fill_q      <= '0;
      dsum_q      <= '0;
      dcnt_q      <= '0;
      psum_q      <= '0;
      pcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      have_prev_q <= have_prev_d;
      sat_q       <= sat_d;
      marks_q     <= marks_d;
      fill_q      <= fill_d;
      dsum_q      <= dsum_d;
      dcnt_q      <= dcnt_d;
      psum_q      <= psum_d;
      pcnt_q      <= pcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    prev_q     <= prev_d;
    last_q     <= last_d;
    win_q      <= win_d;
    scan_q     <= scan_d;
    scan_sat_q <= scan_sat_d;
    n_q        <= n_d;
    k_q        <= k_d;
    nb_q       <= nb_d;
    res_val_q  <= res_val_d;
    res_def_q  <= res_def_d;
    out_val_q  <= out_val_d;
    out_def_q  <= out_def_d;
    out_cnt_q  <= out_cnt_d;
  end

  // checks
  `include "period_jitter_measure_unit_assert.svh"

  `PJM_ASSERT_HOLDS(a_fill_bound, fill_q <= FILL_W'(WIN_DEPTH), "window fill beyond depth")
  `PJM_ASSERT_IMPLIES(a_dsum_needs_count, dcnt_q == '0, dsum_q == '0, "deviation sum without count")
  `PJM_ASSERT_IMPLIES(a_psum_needs_count, pcnt_q == '0, (psum_q == '0) && (marks_q == '0), "period sum or marks without count")

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// period jitter measure unit testbench
// drives pulse sequences through every mode and several register settings,
// predicts each result word and checks it field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import pjm_pkg::*;

  localparam int unsigned PER_BITS   = 16;
  localparam int unsigned CNT_BITS   = 20;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SETTLE     = 250;

  typedef struct {
    bit [VALUE_W-1:0]   value;
    bit                 defined;
    bit [ACC_CNT_W-1:0] count;
  } jitter_word_t;

  // jitter predictor and store of expected result words
  class jitter_board;
    bit [MODE_W-1:0]  mode    = MODE_RST;
    bit [BOUND_W-1:0] floor_p = FLOOR_RST;
    bit [BOUND_W-1:0] ceil_p  = CEILING_RST;
    bit [RATIO_W-1:0] ratio   = RATIO_RST;
    bit [31:0] prev_time;
    bit        have_prev;
    bit [63:0] win [5];
    int        fill;
    bit [4:0]  marks;
    bit [4:0]  sat;
    bit [63:0] dev_sum, dev_cnt, per_sum, per_cnt;
    jitter_word_t pending[$];
    int fails;

    function void clear_seq();
      prev_time = 0; have_prev = 0; fill = 0; marks = 0; sat = 0;
      foreach (win[k]) win[k] = 0;
      dev_sum = 0; dev_cnt = 0; per_sum = 0; per_cnt = 0;
    endfunction

    function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MODE:    mode    = data[MODE_W-1:0];
        CFG_FLOOR:   floor_p = data[BOUND_W-1:0];
        CFG_CEILING: ceil_p  = data[BOUND_W-1:0];
        CFG_RATIO:   ratio   = data[RATIO_W-1:0];
        default: ;
      endcase
    endfunction

    function bit span_ok(int n);
      bit [63:0] lo, hi;
      if (fill < n) return 0;
      for (int k = 0; k < n; k++)
        if (sat[k] || win[k] < floor_p || win[k] > ceil_p) return 0;
      for (int k = 0; k + 1 < n; k++) begin
        lo = (win[k] < win[k+1]) ? win[k] : win[k+1];
        hi = (win[k] < win[k+1]) ? win[k+1] : win[k];
        if (lo == 0 || hi * 256 > 64'(ratio) * lo) return 0;
      end
      return 1;
    endfunction

    function void take(bit [63:0] dev, int n);
      bit [63:0] sum_max;
      bit [63:0] cnt_max;
      sum_max = (64'd1 << SUM_W) - 1;
      cnt_max = (64'd1 << CNT_BITS) - 1;
      if (dev_cnt < cnt_max) begin
        dev_sum = dev_sum + dev;
        if (dev_sum > sum_max) dev_sum = sum_max;
        dev_cnt++;
      end
      for (int k = 0; k < n; k++) begin
        if (!marks[k]) begin
          marks[k] = 1;
          if (per_cnt < cnt_max) begin
            per_sum = per_sum + win[k];
            if (per_sum > sum_max) per_sum = sum_max;
            per_cnt++;
          end
        end
      end
    endfunction

    // absolute deviation of the newest pair or window for the current mode
    function void judge();
      bit [63:0] s, c;
      case (mode)
        MODE_LOCAL, MODE_LOCAL_ABS: begin
          if (span_ok(2)) take(win[0] > win[1] ? win[0] - win[1] : win[1] - win[0], 2);
        end
        MODE_RAP, MODE_DDP: begin
          if (span_ok(3)) begin
            s = win[0] + win[1] + win[2]; c = 3 * win[1];
            take(c > s ? c - s : s - c, 3);
          end
        end
        MODE_PPQ5: begin
          if (span_ok(5)) begin
            s = win[0] + win[1] + win[2] + win[3] + win[4]; c = 5 * win[2];
            take(c > s ? c - s : s - c, 5);
          end
        end
        default: ;
      endcase
    endfunction

    function void note_pulse(bit [31:0] t, bit last);
      bit [31:0] d;
      bit [127:0] num, den, q;
      jitter_word_t w;
      if (have_prev) begin
        d = t - prev_time;
        for (int k = 4; k > 0; k--) win[k] = win[k-1];
        marks = marks << 1;
        sat = sat << 1;
        if (d > (32'd1 << PER_BITS) - 1) begin
          d = (32'd1 << PER_BITS) - 1;
          sat[0] = 1;
        end
        win[0] = 64'(d);
        if (fill < 5) fill++;
        judge();
      end
      prev_time = t;
      have_prev = 1;
      if (!last) return;
      w.value = 0; w.defined = 0;
      if (mode == MODE_LOCAL_ABS) begin
        if (dev_cnt > 0) begin
          q = (128'(dev_sum) << ABS_SHIFT) / 128'(dev_cnt);
          w.value = (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
          w.defined = 1;
        end
      end else if (mode <= MODE_DDP) begin
        if (dev_cnt > 0 && per_cnt > 0 && per_sum > 0) begin
          num = (128'(dev_sum) * 128'(per_cnt)) << FRAC_SHIFT;
          den = 128'(mode == MODE_RAP ? 3 : (mode == MODE_PPQ5 ? 5 : 1))
              * 128'(dev_cnt) * 128'(per_sum);
          q = num / den;
          w.value = (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
          w.defined = 1;
        end
      end
      w.count = dev_cnt[ACC_CNT_W-1:0];
      pending.insert(pending.size(), w);
      clear_seq();
    endfunction

    function void check_word(bit [VALUE_W-1:0] v, bit d, bit [ACC_CNT_W-1:0] c);
      jitter_word_t w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word value %h defined %0d count %0d",
                 $realtime, v, d, c);
        fails++;
        return;
      end
      w = pending.pop_front();
      if (v !== w.value) begin
        $display("%0t: jitter_value expected %h actual %h", $realtime, w.value, v);
        fails++;
      end
      if (d !== w.defined) begin
        $display("%0t: defined expected %0d actual %0d", $realtime, w.defined, d);
        fails++;
      end
      if (c !== w.count) begin
        $display("%0t: accepted_count expected %0d actual %0d", $realtime, w.count, c);
        fails++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [TIME_W-1:0]     pulse_time_i;
  logic                  last_pulse_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [VALUE_W-1:0]    jitter_value_o;
  logic                  defined_o;
  logic [ACC_CNT_W-1:0]  accepted_count_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  jitter_board board;
  int unsigned cycles;
  bit          quiet;
  bit [31:0]   now_time;

  period_jitter_measure_unit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .pulse_time_i     (pulse_time_i),
    .last_pulse_i     (last_pulse_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .jitter_value_o   (jitter_value_o),
    .defined_o        (defined_o),
    .accepted_count_o (accepted_count_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // gap length: mostly none or short, a few long
  function automatic int gap_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver stall
  initial begin
    int n;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      n = gap_len();
      if (n > 0) begin
        out_stall_i = 1'b1;
        repeat (n) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_word(jitter_value_o, defined_o, accepted_count_o);
  end

  task automatic send_pulse(bit [31:0] t, bit last);
    int n;
    @(negedge clk_i);
    n = gap_len();
    if (n > 0) begin
      in_valid_i = 1'b0;
      repeat (n) @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    pulse_time_i = t;
    last_pulse_i = last;
    do @(posedge clk_i); while (in_stall_o);
    board.note_pulse(t, last);
    now_time = t;
  endtask

  task automatic drop_valid();
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic wait_idle();
    drop_valid();
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = data;
    board.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_regs(bit [MODE_W-1:0] m, bit [15:0] fl, bit [15:0] ce, bit [11:0] ra);
    write_reg(CFG_MODE, {13'($urandom), m});
    write_reg(CFG_FLOOR, fl);
    write_reg(CFG_CEILING, ce);
    write_reg(CFG_RATIO, {4'($urandom), ra});
  endtask

  // one pulse sequence; mostly well-formed periods around a base, some noise
  task automatic run_sequence(int len, int noise_pct);
    bit [31:0] base, per;
    int unsigned lo, hi, jit;
    lo = 32'(board.floor_p);
    hi = 32'(board.ceil_p);
    if (lo > hi || $urandom_range(0, 9) == 0) begin
      lo = 1;
      hi = 2000;
    end
    base = $urandom_range(lo, hi);
    jit  = base / 10;
    if ($urandom_range(0, 3) == 0) now_time = $urandom;
    send_pulse(now_time, len == 1);
    for (int i = 1; i < len; i++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        case ($urandom_range(0, 3))
          0: per = 0;
          1: per = $urandom;
          2: per = $urandom_range(0, 65535);
          default: per = base * 2;
        endcase
      end else begin
        per = base + $urandom_range(0, jit) - jit / 2;
      end
      send_pulse(now_time + per, i == len - 1);
    end
  endtask

  initial begin
    bit [15:0] fl, ce;
    bit [11:0] ra;
    int sent;
    board = new();
    board.clear_seq();
    quiet        = 1'b0;
    now_time     = 0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    pulse_time_i = '0;
    last_pulse_i = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = CFG_MODE;
    cfg_wdata_i  = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset settings, first pulse last, extremes of the time field
    send_pulse(32'h0000_0000, 1'b1);
    send_pulse(32'hFFFF_FFFF, 1'b0);
    send_pulse(32'h0000_0063, 1'b0);  // wraps to a short period
    send_pulse(32'h0000_00C8, 1'b0);
    send_pulse(32'h0000_00C8, 1'b0);  // zero period
    send_pulse(32'h0001_5000, 1'b0);  // period too long
    send_pulse(32'h0001_4000, 1'b1);  // backward step
    send_pulse(32'h8000_0000, 1'b0);
    send_pulse(32'h8000_0064, 1'b0);
    send_pulse(32'h8000_00C9, 1'b1);
    wait_idle();
    // every mode, widest limits
    for (int m = 0; m < 8; m++) begin
      set_regs(m[2:0], 16'd0, 16'hFFFF, 12'hFFF);
      run_sequence(7, 0);
      wait_idle();
    end
    // floor above ceiling, tightest ratio
    set_regs(MODE_LOCAL, 16'hFFFF, 16'd0, 12'd256);
    run_sequence(4, 0);
    wait_idle();
    // mode change within a sequence
    set_regs(MODE_RAP, 16'd5, 16'd960, 12'd333);
    send_pulse(32'd1000, 1'b0);
    send_pulse(32'd1100, 1'b0);
    send_pulse(32'd1205, 1'b0);
    send_pulse(32'd1300, 1'b0);
    wait_idle();
    write_reg(CFG_MODE, 16'(MODE_LOCAL));
    send_pulse(32'd1398, 1'b0);
    send_pulse(32'd1500, 1'b1);
    wait_idle();

    // random phases over several register settings
    for (int p = 0; p < 16; p++) begin
      case (p % 4)
        0: begin fl = 0; ce = 16'hFFFF; end
        1: begin fl = FLOOR_RST; ce = CEILING_RST; end
        2: begin
          fl = 16'($urandom_range(0, 400));
          ce = 16'(fl + $urandom_range(0, 3000));
        end
        default: begin fl = 16'($urandom); ce = 16'($urandom); end
      endcase
      case ($urandom_range(0, 4))
        0: ra = 12'd256;
        1: ra = 12'hFFF;
        default: ra = 12'($urandom_range(270, 700));
      endcase
      set_regs((p < 8) ? p[2:0] : 3'($urandom_range(0, 4)), fl, ce, ra);
      quiet = (p % 5 == 2);
      sent = 0;
      while (sent < 90) begin
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 14);
        run_sequence(len, ($urandom_range(0, 3) == 0) ? 25 : 3);
        sent += len;
      end
      wait_idle();
    end
    quiet = 1'b0;

    if (board.fails == 0 && board.pending.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
